// ----- rtl/mch_pkg.sv -----
`timescale 1ns / 1ps

package mch_pkg;

   localparam logic [1:0] ACT_RECORD     = 2'd0;
   localparam logic [1:0] ACT_SET_ACTIVE = 2'd1;
   localparam logic [1:0] ACT_CLEAR      = 2'd2;
   localparam logic [1:0] ACT_READ       = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] color_value;
      logic        color_valid;
      logic [7:0]  slot_index;
   } mch_req_type;

   typedef struct packed {
      logic [31:0] slot_color;
      logic        slot_filled;
      logic        slot_is_active;
      logic [8:0]  entry_count;
   } mch_rsp_type;

   // Broadcast from the controller to every cell of the chain
   typedef struct packed {
      logic        compare;
      logic        write;
      logic [31:0] color;
   } mch_bcast_type;

endpackage

// ----- rtl/mch_cell.sv -----
`timescale 1ns / 1ps

module mch_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mch_pkg::mch_bcast_type bcast,
   input  logic                  filled,
   input  logic                  shift_en,
   input  logic [31:0]           prev_color,
   output logic [31:0]           entry_color,
   output logic                  match
);

   logic [31:0] entry_ff;
   logic [31:0] entry_in;
   logic        match_ff;
   logic        match_in;

   always_comb begin
      entry_in = entry_ff;
      if (bcast.write && shift_en) begin
         entry_in = prev_color;
      end
   end

   always_comb begin
      match_in = match_ff;
      if (bcast.compare) begin
         match_in = filled && (entry_ff == bcast.color);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign entry_color = entry_ff;
   assign match       = match_ff;

endmodule

// ----- rtl/mru_color_history_list.sv -----
`timescale 1ns / 1ps
// Most-recently-used list of up to CAPACITY distinct ARGB colors plus one
// active color. Every request transaction on req_ (valid/stall, payload
// req_data) yields exactly one response transaction on rsp_ (payload
// rsp_data): record, set active, clear, or read one slot, each reporting
// the entry count after the operation.
// The list lives in a chain of cells, one color per cell. In the compare
// state after acceptance every cell compares its color with the request
// color; in the commit state the matching position is encoded, the cells
// at or below it (all cells on a miss) shift one place up the chain and
// cell 0 loads the new color. Reads take the slot through an AND-OR
// select over the cells in the commit state. One transaction is in flight
// at a time: the next is accepted as the previous one commits.
// The response sits in an output register. A new request is still accepted
// while it waits; when rsp_stall holds, the next update waits in the commit
// state and the list is not touched until the register drains.
// Reset (synchronous) empties the list and clears the active color; entry
// colors themselves are not cleared and read as undefined until written.
module mru_color_history_list #(
   parameter int CAPACITY = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mch_pkg::mch_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mch_pkg::mch_rsp_type rsp_data
);

   localparam int IW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > 8) ? CW : 8;
   localparam int ECW  = (CW > 9) ? CW : 9;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EVAL   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0]            state_ff;
   logic [1:0]            state_in;
   mch_pkg::mch_req_type  req_ff;
   mch_pkg::mch_req_type  req_in;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [31:0]           active_ff;
   logic [31:0]           active_in;
   logic                  active_set_ff;
   logic                  active_set_in;
   mch_pkg::mch_rsp_type  rsp_ff;
   mch_pkg::mch_rsp_type  rsp_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   logic                  req_take;
   logic                  commit_go;
   mch_pkg::mch_bcast_type bcast;
   logic [31:0]           entries [CAPACITY];
   logic [CAPACITY-1:0]   match_vec;
   logic [CAPACITY-1:0]   shift_vec;
   logic [CAPACITY-1:0]   filled_vec;
   logic                  hit;
   logic [IW-1:0]         hit_pos;
   logic [31:0]           read_color;
   logic                  read_filled;
   logic [ECW-1:0]        count_wide;

   assign commit_go = (state_ff == ST_COMMIT) && !(rsp_valid_ff && rsp_stall);
   assign req_stall = !((state_ff == ST_IDLE) || commit_go);
   assign req_take  = req_valid && !req_stall;

   assign bcast.compare = (state_ff == ST_EVAL);
   assign bcast.write   = commit_go && (req_ff.action == mch_pkg::ACT_RECORD)
                          && req_ff.color_valid;
   assign bcast.color   = req_ff.color_value;

   // Cell chain: cell 0 loads the new color, the rest take their neighbor's
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign filled_vec[i] = (count_ff > CW'(i));
      assign shift_vec[i]  = !hit || (IW'(i) <= hit_pos);
      if (i == 0) begin : g_head
         mch_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .bcast       (bcast),
            .filled      (filled_vec[i]),
            .shift_en    (shift_vec[i]),
            .prev_color  (bcast.color),
            .entry_color (entries[i]),
            .match       (match_vec[i])
         );
      end else begin : g_body
         mch_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .bcast       (bcast),
            .filled      (filled_vec[i]),
            .shift_en    (shift_vec[i]),
            .prev_color  (entries[i-1]),
            .entry_color (entries[i]),
            .match       (match_vec[i])
         );
      end
   end

   // Encode the single matching cell
   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_vec[i]) begin
            hit_pos = hit_pos | IW'(i);
         end
      end
   end
   assign hit = |match_vec;

   always_comb begin
      read_color = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (i < 256) begin
            if (req_ff.slot_index == 8'(i)) begin
               read_color = read_color | entries[i];
            end
         end
      end
   end
   assign read_filled = (CMPW'(req_ff.slot_index) < CMPW'(count_ff));

   always_comb begin
      req_in        = req_ff;
      state_in      = state_ff;
      count_in      = count_ff;
      active_in     = active_ff;
      active_set_in = active_set_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      count_wide    = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (req_take) begin
         req_in = req_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_go) begin
               state_in = req_take ? ST_EVAL : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (commit_go) begin
         rsp_in.slot_color     = '0;
         rsp_in.slot_filled    = 1'b0;
         rsp_in.slot_is_active = 1'b0;
         unique case (req_ff.action)
            mch_pkg::ACT_RECORD: begin
               if (req_ff.color_valid) begin
                  if (!hit && (count_ff < CW'(CAPACITY))) begin
                     count_in = count_ff + CW'(1);
                  end
                  active_in     = req_ff.color_value;
                  active_set_in = 1'b1;
               end
            end
            mch_pkg::ACT_SET_ACTIVE: begin
               if (req_ff.color_valid) begin
                  active_in     = req_ff.color_value;
                  active_set_in = 1'b1;
               end
            end
            mch_pkg::ACT_CLEAR: begin
               count_in = '0;
            end
            mch_pkg::ACT_READ: begin
               if (read_filled) begin
                  rsp_in.slot_color     = read_color;
                  rsp_in.slot_filled    = 1'b1;
                  rsp_in.slot_is_active = active_set_ff && (read_color == active_ff);
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
         count_wide         = ECW'(count_in);
         rsp_in.entry_count = count_wide[8:0];
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         active_ff     <= '0;
         active_set_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         active_ff     <= active_in;
         active_set_ff <= active_set_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |-> $onehot0(match_vec))
      else $error("more than one cell matched the request color");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_take_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_EVAL))
      else $error("accepted transaction did not enter compare stage");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_COMMIT))
      else $error("response raised outside commit stage");
`endif

endmodule

// ----- dv/tb_mru_color_history_list.sv -----
`timescale 1ns / 1ps

module tb_mru_color_history_list;

   localparam int HIST_DEPTH = 256;
   localparam int MAX_SHOWN = 10;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   mch_pkg::mch_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   mch_pkg::mch_rsp_type rsp_data;

   mru_color_history_list #(
      .CAPACITY(HIST_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   // Shadow copy of the history list and the active color
   logic [31:0] mru_colors [HIST_DEPTH];
   int          mru_count;
   logic [31:0] active_color_q;
   logic        active_known;

   mch_pkg::mch_rsp_type due_slot_reports [$];

   int send_idle_pct;
   int rcv_stall_pct;
   int hold_left;

   int mismatches;
   int num_accepted;
   int num_checked;
   int num_filled_reads;
   int num_evictions;

   logic [31:0] palette [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_0000, 32'h00FF_FFFF,
                                32'h8080_8080, 32'h7F7F_7F7F, 32'hFF12_3456, 32'h0000_0001};

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("FAIL mru_color_history_list");
      $finish;
   end

   // Receiver: long hold-off when requested, otherwise random stalls
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
         end
      end
   end

   function automatic mch_pkg::mch_rsp_type apply_color_request(
      input mch_pkg::mch_req_type rq);
      mch_pkg::mch_rsp_type rs;
      int pos;
      int i;
      rs = '0;
      case (rq.action)
         mch_pkg::ACT_RECORD: begin
            if (rq.color_valid) begin
               pos = mru_count;
               for (i = 0; i < mru_count; i++) begin
                  if (pos == mru_count && mru_colors[i] == rq.color_value) pos = i;
               end
               if (pos == mru_count) begin
                  if (mru_count < HIST_DEPTH) mru_count++;
                  else num_evictions++;
                  pos = mru_count - 1;
               end
               for (i = pos; i > 0; i--) mru_colors[i] = mru_colors[i-1];
               mru_colors[0] = rq.color_value;
               active_color_q = rq.color_value;
               active_known = 1'b1;
            end
         end
         mch_pkg::ACT_SET_ACTIVE: begin
            if (rq.color_valid) begin
               active_color_q = rq.color_value;
               active_known = 1'b1;
            end
         end
         mch_pkg::ACT_CLEAR: begin
            mru_count = 0;
         end
         default: begin
            if (int'(rq.slot_index) < mru_count) begin
               rs.slot_color = mru_colors[rq.slot_index];
               rs.slot_filled = 1'b1;
               rs.slot_is_active = active_known && (rs.slot_color == active_color_q);
               num_filled_reads++;
            end
         end
      endcase
      rs.entry_count = mru_count[8:0];
      return rs;
   endfunction

   function automatic mch_pkg::mch_req_type mk_req(input logic [1:0] act,
                                                   input logic [31:0] col,
                                                   input logic vld,
                                                   input logic [7:0] slot);
      mch_pkg::mch_req_type rq;
      rq.action = act;
      rq.color_value = col;
      rq.color_valid = vld;
      rq.slot_index = slot;
      return rq;
   endfunction

   function automatic logic [31:0] pick_color();
      int r;
      r = $urandom_range(99);
      if (r < 40) return palette[$urandom_range(7)];
      if (r < 70 && mru_count > 0) return mru_colors[$urandom_range(mru_count - 1)];
      return $urandom;
   endfunction

   function automatic mch_pkg::mch_req_type make_random_request();
      mch_pkg::mch_req_type rq;
      int r;
      r = $urandom_range(99);
      if (r < 35) rq.action = mch_pkg::ACT_RECORD;
      else if (r < 50) rq.action = mch_pkg::ACT_SET_ACTIVE;
      else if (r < 53) rq.action = mch_pkg::ACT_CLEAR;
      else rq.action = mch_pkg::ACT_READ;
      rq.color_value = pick_color();
      rq.color_valid = ($urandom_range(9) != 0);
      if (mru_count > 0 && $urandom_range(99) < 70)
         rq.slot_index = 8'($urandom_range(mru_count - 1));
      else
         rq.slot_index = 8'($urandom_range(255));
      return rq;
   endfunction

   // Hold valid and payload until accepted, then record the expected report
   task automatic send_req(input mch_pkg::mch_req_type rq);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (req_stall);
      num_accepted++;
      due_slot_reports.push_back(apply_color_request(rq));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_slot_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      mch_pkg::mch_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         num_checked++;
         if (due_slot_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("%t: unexpected transaction color=%h filled=%b active=%b count=%0d",
                        $realtime, rsp_data.slot_color, rsp_data.slot_filled,
                        rsp_data.slot_is_active, rsp_data.entry_count);
         end else begin
            want = due_slot_reports.pop_front();
            if (rsp_data.slot_color !== want.slot_color ||
                rsp_data.slot_filled !== want.slot_filled ||
                rsp_data.slot_is_active !== want.slot_is_active ||
                rsp_data.entry_count !== want.entry_count) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN) begin
                  $display("%t: mismatch exp color=%h filled=%b active=%b count=%0d",
                           $realtime, want.slot_color, want.slot_filled,
                           want.slot_is_active, want.entry_count);
                  $display("%t:          got color=%h filled=%b active=%b count=%0d",
                           $realtime, rsp_data.slot_color, rsp_data.slot_filled,
                           rsp_data.slot_is_active, rsp_data.entry_count);
               end
            end
         end
      end
   end

   task automatic test_directed();
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b0, 8'd0));
      send_req(mk_req(mch_pkg::ACT_READ, 32'hFFFF_FFFF, 1'b1, 8'd255));
      // invalid colors change nothing
      send_req(mk_req(mch_pkg::ACT_RECORD, 32'hDEAD_BEEF, 1'b0, 8'd0));
      send_req(mk_req(mch_pkg::ACT_SET_ACTIVE, 32'hDEAD_BEEF, 1'b0, 8'd0));
      send_req(mk_req(mch_pkg::ACT_SET_ACTIVE, 32'h0000_0000, 1'b1, 8'd17));
      send_req(mk_req(mch_pkg::ACT_RECORD, 32'h0000_0000, 1'b1, 8'd0));
      send_req(mk_req(mch_pkg::ACT_RECORD, 32'hFFFF_FFFF, 1'b1, 8'd255));
      send_req(mk_req(mch_pkg::ACT_RECORD, 32'h8000_0001, 1'b1, 8'd1));
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b1, 8'd0));
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b1, 8'd1));
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b1, 8'd2));
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b1, 8'd3));
      // existing color moves to the front without growing the list
      send_req(mk_req(mch_pkg::ACT_RECORD, 32'h0000_0000, 1'b1, 8'd0));
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b0, 8'd0));
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b0, 8'd2));
      send_req(mk_req(mch_pkg::ACT_SET_ACTIVE, 32'h0000_0000, 1'b1, 8'd0));
      send_req(mk_req(mch_pkg::ACT_SET_ACTIVE, 32'hFFFF_FFFF, 1'b1, 8'd0));
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b1, 8'd1));
      send_req(mk_req(mch_pkg::ACT_SET_ACTIVE, 32'h7FFF_FFFE, 1'b1, 8'd0));
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b1, 8'd0));
      // clear empties the list, then the list is refilled and read
      send_req(mk_req(mch_pkg::ACT_CLEAR, 32'h1234_5678, 1'b1, 8'hAA));
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b1, 8'd0));
      send_req(mk_req(mch_pkg::ACT_RECORD, 32'h5A5A_A5A5, 1'b1, 8'd0));
      send_req(mk_req(mch_pkg::ACT_SET_ACTIVE, 32'h7FFF_FFFE, 1'b1, 8'd0));
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b1, 8'd0));
   endtask

   task automatic test_capacity_fill();
      send_idle_pct = 12;
      rcv_stall_pct = 12;
      repeat (HIST_DEPTH + 14)
         send_req(mk_req(mch_pkg::ACT_RECORD, $urandom, 1'b1, 8'($urandom_range(255))));
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b0, 8'd255));
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b0, 8'd128));
      // pull the oldest entry to the front, then a fresh color evicts the tail
      send_req(mk_req(mch_pkg::ACT_RECORD, mru_colors[HIST_DEPTH-1], 1'b1, 8'd0));
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b0, 8'd255));
      send_req(mk_req(mch_pkg::ACT_RECORD, $urandom, 1'b1, 8'd0));
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b0, 8'd255));
      send_req(mk_req(mch_pkg::ACT_READ, 32'h0, 1'b0, 8'd0));
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      @(posedge clock);
      hold_left = 80;
      repeat (24) send_req(make_random_request());
      wait_drained();
   endtask

   task automatic test_random_phases();
      int idle_mix [4] = '{0, 56, 0, 12};
      int stall_mix [4] = '{0, 0, 56, 12};
      int p;
      for (p = 0; p < 4; p++) begin
         send_idle_pct = idle_mix[p];
         rcv_stall_pct = stall_mix[p];
         repeat (110) send_req(make_random_request());
         wait_drained();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      hold_left = 0;
      mismatches = 0;
      num_accepted = 0;
      num_checked = 0;
      num_filled_reads = 0;
      num_evictions = 0;
      mru_count = 0;
      active_color_q = '0;
      active_known = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      wait_drained();
      test_capacity_fill();
      test_backpressure();
      test_random_phases();
      wait_drained();

      mismatches += due_slot_reports.size();
      $display("Sent %0d transactions: %0d reads of filled slots, %0d evictions at capacity,",
               num_accepted, num_filled_reads, num_evictions);
      $display("idle/stall mixes and a long output hold-off; %0d results checked, %0d errors",
               num_checked, mismatches);
      if (mismatches == 0) begin
         $display("PASS mru_color_history_list");
      end else begin
         $display("FAIL mru_color_history_list");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/mch_pkg.sv
rtl/mch_cell.sv
rtl/mru_color_history_list.sv
dv/tb_mru_color_history_list.sv
